// ===== src/rational_arith_reduce_macros.svh =====
// Assertion macros for the rational reducer
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define RAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define RAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/rar_pkg.sv =====
`timescale 1ns / 1ps
package rar_pkg;
  localparam int unsigned OperandBitsDef = 32;
  localparam int unsigned WideBits = 65;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_MUL  = 2'd2,
    KIND_DIV  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV1,
    BK_GCD,
    BK_DIV2,
    BK_DIV3,
    BK_OUT
  } bk_state_e;

  // Queue entry between front and back
  typedef struct packed {
    logic [WideBits-1:0] num;
    logic [63:0]         den;
  } work_t;
endpackage

// ===== src/rational_arith_reduce.sv =====
// A zero denominator skips the divider; otherwise the back end runs three divisions plus
// one division per Euclid step.
// Throughput: one transaction at a time in the back end; the bit-serial divider sets it.
// The front end registers the products and buffers two transactions.
// Reset: rst_ni asynchronous active low clears all control state.
`timescale 1ns / 1ps
`include "rational_arith_reduce_macros.svh"
module rational_arith_reduce import rar_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [OperandBits-1:0] first_num_i,
  input  logic [OperandBits-1:0] first_den_i,
  input  logic [OperandBits-1:0] second_num_i,
  input  logic [OperandBits-1:0] second_den_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [63:0]            result_num_o,
  output logic [63:0]            result_den_o,
  output logic [1:0]             status_o
);
  logic  q_valid, q_pop;
  work_t q_data;

  rar_front #(.OperandBits(OperandBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .first_num_i, .first_den_i, .second_num_i, .second_den_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  rar_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .result_num_o, .result_den_o, .status_o
  );

  `RAR_ASSERT_IMP(a_pop_valid, clk_i, rst_ni, q_pop, q_valid)
  `RAR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK,
    result_num_o == '0 && result_den_o == '0)
  `RAR_ASSERT_IMP(a_ok_den, clk_i, rst_ni, out_valid_o && status_o == ST_OK,
    result_den_o != '0)
endmodule

// ===== src/rar_front.sv =====
`timescale 1ns / 1ps
module rar_front import rar_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [OperandBits-1:0] first_num_i,
  input  logic [OperandBits-1:0] first_den_i,
  input  logic [OperandBits-1:0] second_num_i,
  input  logic [OperandBits-1:0] second_den_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output work_t                  q_data_o
);
  localparam int unsigned ProdBits = 2 * OperandBits;

  // Stage one: register the operand products (one multiplier level)
  logic                s1_valid_q;
  logic [ProdBits-1:0] p1_q, p2_q, pd_q;
  logic                s1_add_q;
  logic                s1_full;
  logic                accept;

  // Two-entry queue
  logic [1:0] cnt_q;
  work_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic       push;
  work_t      push_data;
  logic [WideBits-1:0] sum;

  assign s1_full    = s1_valid_q;
  assign in_stall_o = s1_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = s1_valid_q && (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Form the unreduced products per kind
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_add_q <= (kind_i == KIND_ADD);
      case (kind_i)
        KIND_INIT: begin
          p1_q <= ProdBits'(first_num_i);
          p2_q <= '0;
          pd_q <= ProdBits'(first_den_i);
        end
        KIND_ADD: begin
          p1_q <= first_num_i * second_den_i;
          p2_q <= first_den_i * second_num_i;
          pd_q <= first_den_i * second_den_i;
        end
        KIND_MUL: begin
          p1_q <= first_num_i * second_num_i;
          p2_q <= '0;
          pd_q <= first_den_i * second_den_i;
        end
        default: begin
          p1_q <= first_num_i * second_den_i;
          p2_q <= '0;
          pd_q <= first_den_i * second_num_i;
        end
      endcase
    end
  end

  assign sum = WideBits'(p1_q) + (s1_add_q ? WideBits'(p2_q) : '0);
  always_comb begin
    push_data.num = sum;
    push_data.den = 64'(pd_q);
  end

  // Advance the queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= push_data;
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = ent_q[rd_ptr_q];
endmodule

// ===== src/rar_divider.sv =====
`timescale 1ns / 1ps
module rar_divider import rar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WideBits-1:0] dividend_i,
  input  logic [63:0]         divisor_i,
  output logic                done_o,
  output logic [WideBits-1:0] quot_o,
  output logic [63:0]         rem_o
);
  // Restoring division, one bit per cycle
  localparam int unsigned CntBits = $clog2(WideBits + 1);
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q;
  logic [WideBits-1:0] quot_q;
  logic [63:0]         rem_q, d_q;
  logic [64:0]         shifted;
  logic                take;

  assign shifted = {rem_q, quot_q[WideBits-1]};
  assign take    = shifted >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(WideBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      d_q    <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[WideBits-2:0], take};
      rem_q  <= take ? 64'(shifted - {1'b0, d_q}) : shifted[63:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ===== src/rar_back.sv =====
`timescale 1ns / 1ps
module rar_back import rar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  work_t               q_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         result_num_o,
  output logic [63:0]         result_den_o,
  output logic [1:0]          status_o
);
  bk_state_e state_q, state_d;
  work_t     w_q;
  logic [63:0] x_q, y_q, g_q, rnum_q, rden_q;
  logic [1:0]  st_q;
  logic        ovf_q;

  logic                dv_start, dv_done;
  logic [WideBits-1:0] dv_dend, dv_quot;
  logic [63:0]         dv_dsor, dv_rem;
  logic                gcd_step;

  rar_divider u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .dividend_i(dv_dend), .divisor_i(dv_dsor),
    .done_o(dv_done), .quot_o(dv_quot), .rem_o(dv_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (q_valid_i) state_d = (q_data_i.den == '0) ? BK_OUT : BK_DIV1;
      BK_DIV1: if (dv_done) state_d = (dv_rem == '0) ? BK_DIV2 : BK_GCD;
      BK_GCD:  if (dv_done && dv_rem == '0) state_d = BK_DIV2;
      BK_DIV2: if (dv_done) state_d = BK_DIV3;
      BK_DIV3: if (dv_done) state_d = BK_OUT;
      BK_OUT:  if (!out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and divider launches
  always_comb begin
    q_pop_o  = (state_q == BK_IDLE) && q_valid_i;
    dv_start = 1'b0;
    dv_dend  = w_q.num;
    dv_dsor  = w_q.den;
    gcd_step = (state_q == BK_GCD) && dv_done && (dv_rem != '0);
    case (state_q)
      BK_IDLE: begin
        dv_start = q_valid_i && (q_data_i.den != '0);
        dv_dend  = q_data_i.num;
        dv_dsor  = q_data_i.den;
      end
      BK_DIV1: begin
        // gcd(den, rem): first step den % rem, or divide by den when rem is zero
        dv_start = dv_done;
        dv_dend  = (dv_rem != '0) ? WideBits'(w_q.den) : w_q.num;
        dv_dsor  = (dv_rem != '0) ? dv_rem : w_q.den;
      end
      BK_GCD: begin
        dv_start = dv_done;
        dv_dend  = (dv_rem != '0) ? WideBits'(y_q) : w_q.num;
        dv_dsor  = (dv_rem != '0) ? dv_rem : y_q;
      end
      BK_DIV2: begin
        dv_start = dv_done;
        dv_dend  = WideBits'(w_q.den);
        dv_dsor  = g_q;
      end
      default: ;
    endcase
    out_valid_o = (state_q == BK_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // Hold operands and results
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: if (q_valid_i) begin
        w_q    <= q_data_i;
        st_q   <= (q_data_i.den == '0) ? ST_ZERO_DEN : ST_OK;
        rnum_q <= '0;
        rden_q <= '0;
      end
      BK_DIV1: if (dv_done) begin
        x_q <= w_q.den;
        y_q <= dv_rem;
        if (dv_rem == '0) begin
          g_q <= w_q.den;
        end
      end
      BK_GCD: if (dv_done) begin
        if (dv_rem == '0) g_q <= y_q;
        else y_q <= dv_rem;
      end
      BK_DIV2: if (dv_done) begin
        ovf_q  <= dv_quot[WideBits-1];
        rnum_q <= dv_quot[63:0];
      end
      BK_DIV3: if (dv_done) begin
        if (ovf_q) begin
          st_q   <= ST_OVERFLOW;
          rnum_q <= '0;
          rden_q <= '0;
        end else begin
          rden_q <= dv_quot[63:0];
        end
      end
      default: ;
    endcase
  end

  assign result_num_o = rnum_q;
  assign result_den_o = rden_q;
  assign status_o     = st_q;
  logic unused;
  assign unused = ^{x_q, gcd_step};
endmodule
